/* rtl/slave_clock_sync_filter_top_assert.svh */
// Assertion macros shared by the filter RTL.
// Each expects signals clk and rst_n in scope.
`ifndef SLAVE_CLOCK_SYNC_FILTER_TOP_ASSERT_SVH
`define SLAVE_CLOCK_SYNC_FILTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCSF_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCSF_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scsf_pkg.sv */
package scsf_pkg;

    localparam int DATA_W   = 64;
    localparam int SAMPLE_W = 32;
    localparam int LIMIT_W  = 20;
    localparam int OP_W     = 2;

    // one request to the shared adder: a + b, or a - b when sub is set
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sub;
    } alu_req_t;

endpackage

/* rtl/scsf_alu.sv */
module scsf_alu
(
    input  scsf_pkg::alu_req_t              req,
    output logic [scsf_pkg::DATA_W-1:0]     result
);

    logic [scsf_pkg::DATA_W-1:0] b_op;

    assign b_op   = req.sub ? ~req.b : req.b;
    assign result = req.a + b_op + scsf_pkg::DATA_W'(req.sub);

endmodule

/* rtl/scsf_window.sv */
module scsf_window
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic                            clk,
    input  logic                            we,
    input  logic [ADDR_W-1:0]               addr,
    input  logic [scsf_pkg::SAMPLE_W-1:0]   wdata,
    output logic [scsf_pkg::SAMPLE_W-1:0]   rdata
);

    logic [scsf_pkg::SAMPLE_W-1:0] window_mem [DEPTH];
    logic [scsf_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            window_mem[addr] <= wdata;
        end
        rdata_reg <= window_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/scsf_div.sv */
module scsf_div
#(
    parameter int DIVISOR    = 8,
    parameter int DIVIDEND_W = 35
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    output logic                    done,
    output logic [DIVIDEND_W-1:0]   quotient
);

    // quotient = (dividend * RECIP) >> SHIFT with RECIP = ceil(2^SHIFT / DIVISOR);
    // exact for every dividend below DIVISOR * 2^(DIVIDEND_W - clog2(DIVISOR))
    localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
    localparam int DIGIT_W = 16;
    localparam int DIGITS  = (DIVIDEND_W + DIGIT_W) / DIGIT_W;
    localparam int RECIP_W = DIGITS * DIGIT_W;
    localparam int ACC_W   = SHIFT + DIVIDEND_W;
    localparam int CNT_W   = $clog2(DIGITS + 1);
    localparam logic [63:0] POW        = 64'd1 << SHIFT;
    localparam logic [63:0] RECIP_FULL = (POW + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [DIVIDEND_W-1:0]         dvd_reg;
    logic [RECIP_W-1:0]            recip_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic [DIVIDEND_W+DIGIT_W-1:0] partial;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    // one reciprocal digit per cycle, most significant first
    assign partial = dvd_reg * recip_reg[RECIP_W-1 -: DIGIT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIGITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg   <= dividend;
            recip_reg <= RECIP;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            recip_reg <= recip_reg << DIGIT_W;
            acc_reg   <= (acc_reg << DIGIT_W) + ACC_W'(partial);
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[ACC_W-1 -: DIVIDEND_W];

endmodule

/* rtl/slave_clock_sync_filter_top.sv */
// Slave clock synchroniser. Keeps a 64-bit local clock, a window of
// WINDOW_DEPTH one-way delay samples and an averaged clock deviation.
// Input word: s_tuser is the operation (0 tick, 1 delay sample, 2 master
// time, 3 no-op), s_tdata the sample (low 32 bits) or master time. Every
// input word yields exactly one output word {deviation, mean, local time}.
// Sums and clock updates run on one shared 64-bit adder under a small sequencer;
// the window mean is refreshed after each sample by a reciprocal multiply
// taking one 16-bit digit per cycle (three digits at any supported depth),
// so the block takes one word at a time and holds s_tready low meanwhile.
// Steps per word, from accept until ready again:
//   no-op: output; tick: increment, output; master time: raw deviation,
//   averaging, halving (skipped for the first one), base, correction, output;
//   delay sample: read, subtract, add, then the multiply; first delay sample:
//   one window slot written per cycle through the single RAM port, then the multiply.
// A new word is accepted while the previous result still waits on
// m_tready; the block only stalls at its final step until the output
// register is free. deviation_limit is written through cfg_we/cfg_wdata
// (reset value 100) and must only change while the block is idle.
`include "slave_clock_sync_filter_top_assert.svh"

module slave_clock_sync_filter_top
#(
    parameter int WINDOW_DEPTH = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    // input stream
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [63:0]    s_tdata,    // [63:0] content
    input  logic [1:0]     s_tuser,    // [1:0] operation
    // result stream
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [159:0]   m_tdata,    // [63:0] local_time_out, [95:64] delay_mean,
                                       // [159:96] deviation_out
    // deviation_limit register
    input  logic           cfg_we,
    input  logic [19:0]    cfg_wdata
);

    localparam int DATA_W   = scsf_pkg::DATA_W;
    localparam int SAMPLE_W = scsf_pkg::SAMPLE_W;
    localparam int LIMIT_W  = scsf_pkg::LIMIT_W;
    localparam int PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef enum logic [scsf_pkg::OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_DELAY  = 2'd1,
        OP_MASTER = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_TICK = 15'h0002,
        ST_FILL = 15'h0004,
        ST_RD   = 15'h0008,
        ST_SUB  = 15'h0010,
        ST_ADD  = 15'h0020,
        ST_DIVS = 15'h0040,
        ST_DIV  = 15'h0080,
        ST_RAW1 = 15'h0100,
        ST_RAW2 = 15'h0200,
        ST_AVG  = 15'h0400,
        ST_HALF = 15'h0800,
        ST_BASE = 15'h1000,
        ST_CORR = 15'h2000,
        ST_OUT  = 15'h4000
    } state_t;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HI   = 2'd1,
        CLAMP_LO   = 2'd2
    } clamp_t;

    state_t                state_reg, state_next;
    clamp_t                clamp_reg, clamp_next;
    logic [DATA_W-1:0]     content_reg;
    logic [DATA_W-1:0]     local_reg, local_next;
    logic [DATA_W-1:0]     acc_reg, acc_next;
    logic [DATA_W-1:0]     dev_reg, dev_next;
    logic                  dev_primed_reg, dev_primed_next;
    logic                  win_primed_reg, win_primed_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SAMPLE_W-1:0]   mean_reg, mean_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic                  m_tvalid_reg;
    logic [159:0]          m_tdata_reg;

    scsf_pkg::alu_req_t    alu_req;
    logic [DATA_W-1:0]     alu_result;
    logic                  ram_we;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quot;

    logic                  accept;
    logic                  out_load;
    logic [SAMPLE_W-1:0]   sample;
    logic [DATA_W-1:0]     lim_ext;
    logic [DATA_W-1:0]     neg_lim;
    logic [PTR_W-1:0]      ptr_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign sample    = content_reg[SAMPLE_W-1:0];
    assign lim_ext   = DATA_W'(limit_reg);
    assign neg_lim   = DATA_W'(0) - lim_ext;
    assign ptr_inc   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
    assign div_start = (state_reg == ST_DIVS);

    scsf_alu u_alu
    (
        .req    (alu_req),
        .result (alu_result)
    );

    scsf_window
    #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (PTR_W)
    )
    u_window
    (
        .clk    (clk),
        .we     (ram_we),
        .addr   (ptr_reg),
        .wdata  (sample),
        .rdata  (ram_rdata)
    );

    // window sum over the constant depth gives the mean
    scsf_div
    #(
        .DIVISOR    (WINDOW_DEPTH),
        .DIVIDEND_W (SUM_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer: each arithmetic step hands the shared adder one request
    always_comb
    begin
        state_next      = state_reg;
        clamp_next      = clamp_reg;
        local_next      = local_reg;
        acc_next        = acc_reg;
        dev_next        = dev_reg;
        dev_primed_next = dev_primed_reg;
        win_primed_next = win_primed_reg;
        ptr_next        = ptr_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        alu_req         = '0;
        ram_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (op_t'(s_tuser))
                        OP_TICK:   state_next = ST_TICK;
                        OP_DELAY:  state_next = win_primed_reg ? ST_RD : ST_FILL;
                        OP_MASTER: state_next = ST_RAW1;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_TICK:
            begin
                alu_req.a  = local_reg;
                alu_req.b  = DATA_W'(1);
                local_next = alu_result;
                state_next = ST_OUT;
            end
            // first sample: write it to every slot, summing as we go
            ST_FILL:
            begin
                ram_we    = 1'b1;
                alu_req.a = DATA_W'(sum_reg);
                alu_req.b = DATA_W'(sample);
                sum_next  = alu_result[SUM_W-1:0];
                ptr_next  = ptr_inc;
                if (ptr_reg == PTR_LAST)
                begin
                    win_primed_next = 1'b1;
                    state_next      = ST_DIVS;
                end
            end
            ST_RD:
            begin
                state_next = ST_SUB;
            end
            // drop the sample being replaced, then add the new one
            ST_SUB:
            begin
                ram_we      = 1'b1;
                alu_req.a   = DATA_W'(sum_reg);
                alu_req.b   = DATA_W'(ram_rdata);
                alu_req.sub = 1'b1;
                sum_next    = alu_result[SUM_W-1:0];
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                alu_req.a  = DATA_W'(sum_reg);
                alu_req.b  = DATA_W'(sample);
                sum_next   = alu_result[SUM_W-1:0];
                ptr_next   = ptr_inc;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_quot[SAMPLE_W-1:0];
                    state_next = ST_OUT;
                end
            end
            // raw deviation = local - master - mean
            ST_RAW1:
            begin
                alu_req.a   = local_reg;
                alu_req.b   = content_reg;
                alu_req.sub = 1'b1;
                acc_next    = alu_result;
                state_next  = ST_RAW2;
            end
            ST_RAW2:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = DATA_W'(mean_reg);
                alu_req.sub = 1'b1;
                acc_next    = alu_result;
                state_next  = ST_AVG;
            end
            ST_AVG:
            begin
                if (dev_primed_reg)
                begin
                    alu_req.a  = dev_reg;
                    alu_req.b  = acc_reg;
                    acc_next   = alu_result;
                    state_next = ST_HALF;
                end
                else
                begin
                    dev_next        = acc_reg;
                    dev_primed_next = 1'b1;
                    state_next      = ST_BASE;
                end
            end
            // halve toward zero: add one when negative, then shift arithmetically
            ST_HALF:
            begin
                alu_req.a  = acc_reg;
                alu_req.b  = DATA_W'(acc_reg[DATA_W-1]);
                dev_next   = {alu_result[DATA_W-1], alu_result[DATA_W-1:1]};
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                alu_req.a = content_reg;
                alu_req.b = DATA_W'(mean_reg);
                acc_next  = alu_result;
                if ($signed(dev_reg) > $signed(lim_ext))
                begin
                    clamp_next = CLAMP_HI;
                end
                else if ($signed(dev_reg) < $signed(neg_lim))
                begin
                    clamp_next = CLAMP_LO;
                end
                else
                begin
                    clamp_next = CLAMP_NONE;
                end
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                alu_req.a = acc_reg;
                case (clamp_reg)
                    CLAMP_HI:
                    begin
                        alu_req.b = lim_ext;
                    end
                    CLAMP_LO:
                    begin
                        alu_req.b   = lim_ext;
                        alu_req.sub = 1'b1;
                    end
                    default:
                    begin
                        alu_req.b = dev_reg;
                    end
                endcase
                local_next = alu_result;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clamp_reg      <= CLAMP_NONE;
            local_reg      <= '0;
            dev_reg        <= '0;
            dev_primed_reg <= 1'b0;
            win_primed_reg <= 1'b0;
            ptr_reg        <= '0;
            sum_reg        <= '0;
            mean_reg       <= '0;
            limit_reg      <= LIMIT_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clamp_reg      <= clamp_next;
            local_reg      <= local_next;
            dev_reg        <= dev_next;
            dev_primed_reg <= dev_primed_next;
            win_primed_reg <= win_primed_next;
            ptr_reg        <= ptr_next;
            sum_reg        <= sum_next;
            mean_reg       <= mean_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (accept)
        begin
            content_reg <= s_tdata;
        end
        if (out_load)
        begin
            m_tdata_reg <= {dev_reg, mean_reg, local_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SCSF_CHECK_NEXT(a_busy_after_accept, accept, !s_tready,
        "input accepted but block still ready next cycle")
    `SCSF_CHECK_NEXT(a_result_issued, out_load, m_tvalid,
        "result step finished without a valid output word")
    `SCSF_CHECK_NOW(a_ptr_in_range, 1'b1, ptr_reg <= PTR_LAST,
        "window pointer beyond window depth")
    `SCSF_CHECK_NOW(a_primed_sticky, 1'b1, !$fell(win_primed_reg),
        "window primed flag cleared outside reset")
    `SCSF_CHECK_NOW(a_div_done_in_wait, div_done, state_reg == ST_DIV,
        "divider finished while sequencer not waiting on it")

endmodule

/* tb/sv/scsf_tb_pkg.sv */
package scsf_tb_pkg;

    // operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_DELAY  = 2'd1,
        OP_MASTER = 2'd2,
        OP_NOP    = 2'd3
    } sync_op_t;

    // one output word, split into its fields
    typedef struct packed {
        logic [63:0] deviation;
        logic [31:0] mean;
        logic [63:0] local_time;
    } sync_report_t;

endpackage

/* tb/sv/slave_clock_sync_filter_checker.sv */
module slave_clock_sync_filter_checker
#(
    parameter int WINDOW_DEPTH = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    input  logic         cfg_we,
    input  logic [19:0]  cfg_wdata,
    output int           mismatches,
    output int           reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import scsf_tb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // own copy of the synchroniser state
    logic [63:0]        local_time;
    logic [31:0]        delays [WINDOW_DEPTH];
    int unsigned        slot;
    bit                 delays_filled;
    logic signed [63:0] dev_avg;
    bit                 dev_taken;
    logic [19:0]        limit;

    sync_report_t       reports_due [$];
    sync_report_t       want;
    sync_report_t       got;
    int                 bad;

    function automatic logic [31:0] window_average();
        logic [63:0] total;
        total = '0;
        foreach (delays[i])
            total += {32'd0, delays[i]};
        return 32'(total / 64'(WINDOW_DEPTH));
    endfunction

    // applies one input word to the state and returns the word it should produce
    function automatic sync_report_t advance_sync(sync_op_t op, logic [63:0] content);
        logic [63:0]        mean_w;
        logic [63:0]        base;
        logic signed [63:0] raw;
        logic signed [63:0] lim;
        logic signed [63:0] pair;
        sync_report_t       r;
        case (op)
            OP_TICK:
                local_time = local_time + 64'd1;
            OP_DELAY:
            begin
                if (!delays_filled)
                begin
                    foreach (delays[i])
                        delays[i] = content[31:0];
                    delays_filled = 1'b1;
                end
                else
                begin
                    delays[slot] = content[31:0];
                    slot = (slot + 1) % WINDOW_DEPTH;
                end
            end
            OP_MASTER:
            begin
                mean_w = {32'd0, window_average()};
                raw    = local_time - content - mean_w;
                base   = content + mean_w;
                lim    = {44'd0, limit};
                if (!dev_taken)
                begin
                    dev_avg   = raw;
                    dev_taken = 1'b1;
                end
                else
                begin
                    pair    = dev_avg + raw;
                    dev_avg = pair / 64'sd2;    // signed divide truncates toward zero
                end
                if (dev_avg > lim)
                    local_time = base + lim;
                else if (dev_avg < -lim)
                    local_time = base - lim;
                else
                    local_time = base + dev_avg;
            end
            default:
                ;
        endcase
        r.local_time = local_time;
        r.mean       = window_average();
        r.deviation  = dev_avg;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_time    = '0;
            foreach (delays[i])
                delays[i] = '0;
            slot          = 0;
            delays_filled = 1'b0;
            dev_avg       = '0;
            dev_taken     = 1'b0;
            limit         = 20'd100;
            bad           = 0;
            reports_due.delete();
            mismatches      <= 0;
            reports_pending <= 0;
        end
        else
        begin
            if (cfg_we)
                limit = cfg_wdata;
            // result side first, so a word can never match its own prediction early
            if (m_tvalid && m_tready)
            begin
                got = sync_report_t'(m_tdata);
                if (reports_due.size() == 0)
                begin
                    bad++;
                    if (bad <= REPORT_LIMIT)
                        $display("%0t: unexpected word: time %h mean %h dev %0d",
                                 $realtime, got.local_time, got.mean,
                                 $signed(got.deviation));
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got.local_time !== want.local_time || got.mean !== want.mean ||
                        got.deviation !== want.deviation)
                    begin
                        bad++;
                        if (bad <= REPORT_LIMIT)
                            $display(
                                "%0t: mismatch: time %h/%h mean %h/%h dev %0d/%0d (exp/got)",
                                $realtime, want.local_time, got.local_time,
                                want.mean, got.mean,
                                $signed(want.deviation), $signed(got.deviation));
                    end
                end
            end
            if (s_tvalid && s_tready)
                reports_due.push_back(advance_sync(sync_op_t'(s_tuser), s_tdata));
            mismatches      <= bad;
            reports_pending <= reports_due.size();
        end
    end

endmodule

/* tb/sv/slave_clock_sync_filter_top_tb.sv */
module slave_clock_sync_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scsf_tb_pkg::*;

    localparam int WINDOW_DEPTH  = 8;
    localparam int RESET_CYCLES  = 8;
    // longest word is the first delay sample; allow some slack beyond it
    localparam int SETTLE_CYCLES = 64;
    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 150;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;     // [63:0] content
    logic [1:0]   s_tuser   = '0;     // [1:0] operation
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [159:0] m_tdata;            // [63:0] local time, [95:64] mean, [159:96] deviation
    logic         cfg_we    = 1'b0;
    logic [19:0]  cfg_wdata = '0;

    int           mismatches;
    int           reports_pending;
    int           send_idle_pct = 0;  // chance of a gap before each word
    int           recv_idle_pct = 0;  // chance per cycle of m_tready low
    int           quiet_cycles  = 0;
    // the master time as the stimulus sees it; ticks advance it in step with the
    // local clock, so a sync sent from it gives a deviation we can steer
    logic [63:0]  master_clock  = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    slave_clock_sync_filter_top #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    slave_clock_sync_filter_checker #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog: any handshake on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one word and returns at the edge where it is taken. tvalid is only
    // dropped when a gap is drawn, so back-to-back words see a single update.
    task automatic push_word(sync_op_t op, logic [63:0] content);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= content;
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_TICK)
            master_clock += 64'd1;
    endtask

    // Sync word aimed at a raw deviation of roughly 'offset': the local clock
    // sits near master + mean, so moving the master back by offset raises raw.
    task automatic push_sync(logic signed [63:0] offset);
        master_clock = master_clock - offset;
        push_word(OP_MASTER, master_clock);
    endtask

    // Sender holds off until every word has come back and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(logic [19:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed traffic: ticks, small delay samples and syncs close to
    // the master time, plus a little noise to push into the clamps.
    task automatic random_word();
        int                 pick;
        logic [63:0]        noise;
        logic signed [63:0] offset;
        pick  = $urandom_range(99);
        noise = {$urandom, $urandom};
        if (pick < 45)
            push_word(OP_TICK, noise);
        else if (pick < 62)
            push_word(OP_DELAY, {noise[63:32], 32'($urandom_range(400))});
        else if (pick < 65)
            push_word(OP_DELAY, noise);     // full-range sample, mean jumps
        else if (pick < 95)
        begin
            if ($urandom_range(99) < 80)
                offset = 64'($urandom_range(400)) - 64'sd200;
            else
            begin
                offset = 64'($urandom_range(3000000));
                if ($urandom_range(1) != 0)
                    offset = -offset;
            end
            push_sync(offset);
        end
        else
            push_word(OP_NOP, noise);
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (PHASE_WORDS) random_word();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset limit of 100, no idling on either side
        push_word(OP_NOP, '1);                  // reset state reported unchanged
        push_word(OP_TICK, '1);
        // first sync with an empty window: mean is zero, deviation taken as is;
        // master just below the top so the local clock wraps through zero
        master_clock = 64'hFFFF_FFFF_FFFF_FFF0;
        push_word(OP_MASTER, master_clock);
        push_word(OP_DELAY, '1);                // first sample fills the window
        push_word(OP_DELAY, {32'hFFFF_FFFF, 32'd0});   // high half ignored
        for (int i = 1; i <= 8; i++)            // round the window and wrap the slot
            push_word(OP_DELAY, 64'(i * 10));
        push_sync(64'sd0);                      // inside the limit
        push_sync(64'sd5000);                   // clamped high
        push_sync(-64'sd20000);                 // clamped low
        // large deviations whose running sum overflows, then cancelled again
        push_sync(64'sh4000_0000_0000_0000);
        push_sync(64'sh7000_0000_0000_0000);
        push_sync(64'sh3800_0000_0000_0000);
        push_sync(64'sd0);
        push_word(OP_TICK, '0);
        push_word(OP_NOP, '0);
        settle();

        // zero limit: every correction lands exactly on master + mean
        set_limit(20'd0);
        run_phase(9, 80);
        settle();

        set_limit(20'd1000000);
        run_phase(80, 9);
        settle();

        set_limit(20'($urandom_range(999999, 1)));
        run_phase(0, 0);
        settle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/scsf_pkg.sv
rtl/scsf_alu.sv
rtl/scsf_window.sv
rtl/scsf_div.sv
rtl/slave_clock_sync_filter_top.sv
tb/sv/scsf_tb_pkg.sv
tb/sv/slave_clock_sync_filter_checker.sv
tb/sv/slave_clock_sync_filter_top_tb.sv
